// File: hdl/tstc_pkg.sv
package tstc_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned DIV_STEPS = DATA_W;
    localparam int unsigned MUL_DIGIT = 4;
    localparam int unsigned MUL_STEPS = DATA_W / MUL_DIGIT;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    localparam logic [DATA_W-1:0] CYCLES_PER_TICK_RESET = 32'd1000;
    localparam logic [DATA_W-1:0] FULL_RANGE            = {DATA_W{1'b1}};

    localparam logic KIND_ENTER = 1'b0;
    localparam logic KIND_WAKE  = 1'b1;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic mul_start;
        logic mul_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic kind;
        logic arm;
        logic sleeping;
        logic tick_irq;
    } status_t;

endpackage

// File: hdl/tickless_sleep_timer_control.sv
// an idle entry that arms the timer or a wake on a non-tick interrupt while asleep runs
// the 32-step divider and the 8-step multiplier; other requests go straight to finish
// throughput: one transaction at a time, the next accepted once the result is
// in the output register
// reset: async active low, clears the armed sleep length and sets the tick period to 1000
module tickless_sleep_timer_control
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tstc_pkg::DATA_W-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        kind,
    input  logic [tstc_pkg::DATA_W-1:0] task_next_expire,
    input  logic [tstc_pkg::DATA_W-1:0] soft_timer_next_expire,
    input  logic [tstc_pkg::DATA_W-1:0] counter_before,
    input  logic [tstc_pkg::DATA_W-1:0] counter_now,
    input  logic                        is_tick_irq,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        reload_valid,
    output logic [tstc_pkg::DATA_W-1:0] reload_cycles,
    output logic [tstc_pkg::DATA_W-1:0] advance_ticks,
    output logic [tstc_pkg::DATA_W-1:0] armed_ticks
);

    tstc_pkg::cmd_t    cmd;
    tstc_pkg::status_t status;

    assign cfg_ready = 1'b1;

    tstc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tstc_dp u_dp
    (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cfg_valid              (cfg_valid),
        .cfg_data               (cfg_data),
        .kind                   (kind),
        .task_next_expire       (task_next_expire),
        .soft_timer_next_expire (soft_timer_next_expire),
        .counter_before         (counter_before),
        .counter_now            (counter_now),
        .is_tick_irq            (is_tick_irq),
        .cmd                    (cmd),
        .status                 (status),
        .reload_valid           (reload_valid),
        .reload_cycles          (reload_cycles),
        .advance_ticks          (advance_ticks),
        .armed_ticks            (armed_ticks)
    );

endmodule

// File: hdl/tstc_ctrl.sv
module tstc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  tstc_pkg::status_t status,
    output tstc_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV,
        ST_MSTART,
        ST_MUL,
        ST_DSTART,
        ST_FIN
    } state_t;

    localparam logic [tstc_pkg::CNT_W-1:0] DIV_LAST =
        tstc_pkg::CNT_W'(tstc_pkg::DIV_STEPS - 1);
    localparam logic [tstc_pkg::CNT_W-1:0] MUL_LAST =
        tstc_pkg::CNT_W'(tstc_pkg::MUL_STEPS - 1);

    state_t                     state_reg, state_next;
    logic [tstc_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !(out_valid_reg && out_stall);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cnt_next = '0;
                if (status.kind == tstc_pkg::KIND_ENTER && status.arm)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else if (status.kind == tstc_pkg::KIND_WAKE && status.sleeping
                         && !status.tick_irq)
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = ST_MUL;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    // enter idle divides first (clamp), wake divides last
                    state_next = (status.kind == tstc_pkg::KIND_ENTER) ? ST_MSTART : ST_FIN;
                end
            end
            ST_MSTART:
            begin
                cmd.mul_start = 1'b1;
                cnt_next      = '0;
                state_next    = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST)
                begin
                    state_next = (status.kind == tstc_pkg::KIND_ENTER) ? ST_FIN : ST_DSTART;
                end
            end
            ST_DSTART:
            begin
                cmd.div_start = 1'b1;
                cnt_next      = '0;
                state_next    = ST_DIV;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hdl/tstc_dp.sv
module tstc_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [tstc_pkg::DATA_W-1:0]   cfg_data,
    input  logic                          kind,
    input  logic [tstc_pkg::DATA_W-1:0]   task_next_expire,
    input  logic [tstc_pkg::DATA_W-1:0]   soft_timer_next_expire,
    input  logic [tstc_pkg::DATA_W-1:0]   counter_before,
    input  logic [tstc_pkg::DATA_W-1:0]   counter_now,
    input  logic                          is_tick_irq,
    input  tstc_pkg::cmd_t                cmd,
    output tstc_pkg::status_t             status,
    output logic                          reload_valid,
    output logic [tstc_pkg::DATA_W-1:0]   reload_cycles,
    output logic [tstc_pkg::DATA_W-1:0]   advance_ticks,
    output logic [tstc_pkg::DATA_W-1:0]   armed_ticks
);

    localparam int unsigned W = tstc_pkg::DATA_W;
    localparam int unsigned D = tstc_pkg::MUL_DIGIT;

    // configuration and state
    logic [W-1:0] cpt_reg, cpt_next;
    logic [W-1:0] sleep_reg, sleep_next;

    // latched transaction
    logic         kind_reg, tick_reg;
    logic [W-1:0] s_reg, c_pre_reg, c_now_reg;

    // shared arithmetic unit
    logic [W-1:0] rem_reg, quo_reg, acc_reg, mcand_reg, mplier_reg;

    // result registers
    logic         rvalid_reg;
    logic [W-1:0] reload_reg, advance_reg, armed_reg;

    logic [W-1:0] period;
    logic [W:0]   rem_sh;
    logic [W:0]   div_diff;
    logic         div_ge;
    logic [W+D-1:0] partial;
    logic [W-1:0] s_clamp;
    logic [W-1:0] comp;
    logic [W-1:0] elapsed;
    logic [W-1:0] min_expire;

    assign period     = (cpt_reg == '0) ? W'(1) : cpt_reg;
    assign min_expire = (task_next_expire < soft_timer_next_expire) ?
                        task_next_expire : soft_timer_next_expire;

    // restoring division, one quotient bit per step
    assign rem_sh   = {rem_reg, quo_reg[W-1]};
    assign div_diff = rem_sh - {1'b0, period};
    assign div_ge   = (rem_sh >= {1'b0, period});

    // shift-add multiply, one digit of the multiplier per step
    assign partial = {{D{1'b0}}, mcand_reg} * {{W{1'b0}}, mplier_reg[D-1:0]};

    assign s_clamp = (s_reg >= quo_reg) ? quo_reg : s_reg;
    assign comp    = (c_pre_reg > c_now_reg) ? (period - c_now_reg)
                                             : ({period[W-2:0], 1'b0} - c_now_reg);
    assign elapsed = acc_reg - c_now_reg;

    assign status.kind     = kind_reg;
    assign status.arm      = (s_reg > W'(1));
    assign status.sleeping = (sleep_reg != '0);
    assign status.tick_irq = tick_reg;

    assign reload_valid  = rvalid_reg;
    assign reload_cycles = reload_reg;
    assign advance_ticks = advance_reg;
    assign armed_ticks   = armed_reg;

    always_comb
    begin
        cpt_next   = cfg_valid ? cfg_data : cpt_reg;
        sleep_next = sleep_reg;
        if (cmd.finish)
        begin
            if (kind_reg == tstc_pkg::KIND_ENTER)
            begin
                if (s_reg > W'(1))
                begin
                    sleep_next = s_clamp;
                end
            end
            else
            begin
                sleep_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpt_reg   <= tstc_pkg::CYCLES_PER_TICK_RESET;
            sleep_reg <= '0;
        end
        else
        begin
            cpt_reg   <= cpt_next;
            sleep_reg <= sleep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            tick_reg  <= is_tick_irq;
            s_reg     <= min_expire;
            c_pre_reg <= counter_before;
            c_now_reg <= counter_now;
        end

        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= (kind_reg == tstc_pkg::KIND_ENTER) ? tstc_pkg::FULL_RANGE : elapsed;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_ge ? div_diff[W-1:0] : rem_sh[W-1:0];
            quo_reg <= {quo_reg[W-2:0], div_ge};
        end

        if (cmd.mul_start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= period;
            mplier_reg <= (kind_reg == tstc_pkg::KIND_ENTER) ? s_clamp : sleep_reg;
        end
        else if (cmd.mul_step)
        begin
            acc_reg    <= acc_reg + partial[W-1:0];
            mcand_reg  <= {mcand_reg[W-D-1:0], {D{1'b0}}};
            mplier_reg <= {{D{1'b0}}, mplier_reg[W-1:D]};
        end

        if (cmd.finish)
        begin
            rvalid_reg  <= 1'b0;
            reload_reg  <= '0;
            advance_reg <= '0;
            armed_reg   <= sleep_next;
            if (kind_reg == tstc_pkg::KIND_ENTER)
            begin
                if (s_reg > W'(1))
                begin
                    rvalid_reg <= 1'b1;
                    reload_reg <= acc_reg - comp;
                end
            end
            else if (sleep_reg != '0)
            begin
                if (tick_reg)
                begin
                    advance_reg <= sleep_reg;
                end
                else if (quo_reg < sleep_reg)
                begin
                    // woke early: re-align to the next tick boundary
                    rvalid_reg  <= 1'b1;
                    reload_reg  <= period - rem_reg;
                    advance_reg <= quo_reg + 1'b1;
                end
                else
                begin
                    advance_reg <= sleep_reg;
                end
            end
        end
    end

endmodule
